[rtl/core/qsfd_pkg.sv]
`default_nettype none

package qsfd_pkg;

   // Most results a single input word can cause
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);

   // Result kinds
   localparam logic KIND_DATA     = 1'b0;
   localparam logic KIND_PAIR_END = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_value;
      logic       kind;
   } result_type;

   // All results caused by one input word; last_index = result count - 1
   typedef struct packed {
      logic [SLOT_W-1:0]               last_index;
      result_type [NUM_SLOTS-1:0]      slot;
   } bundle_type;

   // A bundle together with its qualifier, as it moves between stages
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } bundle_msg_type;

endpackage : qsfd_pkg

`default_nettype wire

[rtl/core/qsfd_front.sv]
`default_nettype none

module qsfd_front
   import qsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  in_byte,
   input  wire logic        end_of_string,
   output bundle_msg_type   push_msg
);

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_PCT  = 2'd1;
   localparam logic [1:0] ESC_HEX  = 2'd2;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_F   = 8'h66;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_F    = 8'h46;

   localparam int          DIGIT_A_VALUE = 10;
   localparam int          NIBBLE_SHIFT  = 4;
   localparam logic [4:0]  NO_HEX        = 5'd16;

   typedef struct packed {
      logic [1:0] stage;
      logic [7:0] held;
      logic       value_side;
      logic       pair_open;
   } dec_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]          count;
      result_type [NUM_SLOTS-1:0]  slot;
   } work_type;

   typedef struct packed {
      dec_state_type st;
      work_type      w;
   } step_type;

   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [4:0] r;
      r = NO_HEX;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         r = 5'(c - CHAR_ZERO);
      end else if (c inside {[CHAR_LOW_A:CHAR_LOW_F]}) begin
         r = 5'(c - CHAR_LOW_A + 8'(DIGIT_A_VALUE));
      end else if (c inside {[CHAR_UP_A:CHAR_UP_F]}) begin
         r = 5'(c - CHAR_UP_A + 8'(DIGIT_A_VALUE));
      end
      return r;
   endfunction

   function automatic step_type put(input step_type s, input logic [7:0] b,
                                    input logic v, input logic k);
      step_type r;
      r = s;
      if (s.w.count < COUNT_W'(NUM_SLOTS)) begin
         r.w.slot[s.w.count[SLOT_W-1:0]].out_byte = b;
         r.w.slot[s.w.count[SLOT_W-1:0]].in_value = v;
         r.w.slot[s.w.count[SLOT_W-1:0]].kind     = k;
         r.w.count = s.w.count + COUNT_W'(1);
      end
      return r;
   endfunction

   // Emit a pending escape as literal bytes and drop it
   function automatic step_type flush_escape(input step_type s);
      step_type r;
      r = s;
      if (s.st.stage inside {ESC_PCT, ESC_HEX}) begin
         r = put(r, CHAR_PERCENT, s.st.value_side, KIND_DATA);
         if (s.st.stage == ESC_HEX) begin
            r = put(r, s.st.held, s.st.value_side, KIND_DATA);
         end
      end
      r.st.stage = ESC_NONE;
      r.st.held  = '0;
      return r;
   endfunction

   function automatic step_type close_pair(input step_type s);
      step_type r;
      r = flush_escape(s);
      if (r.st.pair_open) begin
         r = put(r, 8'h00, r.st.value_side, KIND_PAIR_END);
      end
      r.st.pair_open  = 1'b0;
      r.st.value_side = 1'b0;
      return r;
   endfunction

   function automatic step_type plain_byte(input step_type s, input logic [7:0] c);
      step_type r;
      r = s;
      if (c == CHAR_AMP) begin
         r = close_pair(r);
      end else begin
         r.st.pair_open = 1'b1;
         if (c == CHAR_EQUAL && !r.st.value_side) begin
            r.st.value_side = 1'b1;
         end else if (c == CHAR_PLUS) begin
            r = put(r, CHAR_SPACE, r.st.value_side, KIND_DATA);
         end else if (c == CHAR_PERCENT) begin
            r.st.stage = ESC_PCT;
            r.st.held  = '0;
         end else begin
            r = put(r, c, r.st.value_side, KIND_DATA);
         end
      end
      return r;
   endfunction

   dec_state_type state_ff;
   dec_state_type state_in;
   step_type      step;
   logic [4:0]    cur_nib;
   logic [4:0]    held_nib;
   logic [7:0]    decoded;
   logic          do_plain;

   always_comb begin
      cur_nib  = hex_of(in_byte);
      held_nib = hex_of(state_ff.held);
      decoded  = (8'(held_nib[3:0]) << NIBBLE_SHIFT) | {4'd0, cur_nib[3:0]};
      step     = '0;
      step.st  = state_ff;
      do_plain = 1'b0;
      case (state_ff.stage)
         ESC_PCT: begin
            if (cur_nib != NO_HEX) begin
               step.st.stage = ESC_HEX;
               step.st.held  = in_byte;
            end else begin
               step     = flush_escape(step);
               do_plain = 1'b1;
            end
         end
         ESC_HEX: begin
            if (cur_nib != NO_HEX) begin
               step          = put(step, decoded, state_ff.value_side, KIND_DATA);
               step.st.stage = ESC_NONE;
               step.st.held  = '0;
            end else begin
               step     = flush_escape(step);
               do_plain = 1'b1;
            end
         end
         default: begin
            step.st.stage = ESC_NONE;
            do_plain      = 1'b1;
         end
      endcase
      if (do_plain) begin
         step = plain_byte(step, in_byte);
      end
      if (end_of_string) begin
         step    = close_pair(step);
         step.st = '0;
      end
      state_in = step.st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Push a bundle only when the word caused at least one result
   always_comb begin
      push_msg.valid             = accept && (step.w.count != '0);
      push_msg.bundle.slot       = step.w.slot;
      push_msg.bundle.last_index = SLOT_W'(step.w.count - COUNT_W'(1));
   end

endmodule : qsfd_front

`default_nettype wire

[rtl/core/qsfd_queue.sv]
`default_nettype none

module qsfd_queue
   import qsfd_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bundle_msg_type push_msg,
   input  wire logic           pop,
   output logic                full,
   output bundle_msg_type      head_msg
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type           mem [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push_msg.valid && !full;
   assign do_pop   = pop && (count_ff != '0);

   assign head_msg.valid  = (count_ff != '0);
   assign head_msg.bundle = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_msg.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : qsfd_queue

`default_nettype wire

[rtl/core/qsfd_back.sv]
`default_nettype none

module qsfd_back
   import qsfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bundle_msg_type head_msg,
   output logic                head_pop,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_in_value,
   output logic                rsp_kind,
   output logic                rsp_run_last
);

   logic [SLOT_W-1:0] sub_ff;
   logic [SLOT_W-1:0] sub_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        out_ff;
   logic              out_last_ff;
   logic              load;
   logic              at_last;

   // Refill the output register when it is free or being drained
   assign load    = head_msg.valid && (!out_valid_ff || rsp_pop);
   assign at_last = (sub_ff == head_msg.bundle.last_index);
   assign head_pop = load && at_last;

   always_comb begin
      sub_in       = sub_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         sub_in       = at_last ? '0 : sub_ff + SLOT_W'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff      <= head_msg.bundle.slot[sub_ff];
         out_last_ff <= at_last;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_ff.out_byte;
   assign rsp_in_value = out_ff.in_value;
   assign rsp_kind     = out_ff.kind;
   assign rsp_run_last = out_last_ff;

endmodule : qsfd_back

`default_nettype wire

[rtl/core/query_string_form_decoder.sv]
// Query string (form-urlencoded) decoder.
// Input queue port: drive req_in_byte / req_end_of_string and raise req_push; a word is
// taken on each clock edge with req_push high and req_full low. One raw byte per word,
// req_end_of_string on the final byte of a string.
// Result queue port: while rsp_empty is low the oldest result sits on rsp_*; it is taken
// on an edge with rsp_pop high. Each result is a decoded key/value byte or a pair-end
// marker; rsp_run_last flags the last result caused by one input byte.
// With nothing queued ahead, a result reaches rsp_* via the bundle queue write at the edge
// that takes its input word, then the output register load.
// Throughput: one input word per cycle while each byte yields at most one result and the
// receiver keeps rsp_pop high. A byte that yields several results (escape flushes, pair end
// at '&' or end of string, up to four) has them handed out one at a time; the bundle queue of
// QUEUE_DEPTH entries between the decode front and the output serializer absorbs that, and
// req_full rises only once it fills. A receiver that holds rsp_pop low keeps the current
// result stable; the queue then fills and req_full stalls the sender.
// Reset (synchronous, active high) drops all queued results and returns the decoder to
// the start of a new string, in the key, with no escape pending.
`default_nettype none

module query_string_form_decoder
   import qsfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_string,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_in_value,
   output logic            rsp_kind,
   output logic            rsp_run_last
);

   bundle_msg_type push_msg;
   bundle_msg_type head_msg;
   logic           head_pop;
   logic           accept;

   // Take a word only when the bundle queue has room for whatever it may cause
   assign accept = req_push && !req_full;

   // Front: track escape / key-value / pair state, build the result bundle
   qsfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .push_msg      (push_msg)
   );

   // Decouple decode from output draining
   qsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_msg (push_msg),
      .pop      (head_pop),
      .full     (req_full),
      .head_msg (head_msg)
   );

   // Back: hand out the bundle one result per cycle, while rsp_pop drains it, through the output register
   qsfd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_msg     (head_msg),
      .head_pop     (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_in_value (rsp_in_value),
      .rsp_kind     (rsp_kind),
      .rsp_run_last (rsp_run_last)
   );

endmodule : query_string_form_decoder

`default_nettype wire
